@@ rtl/core/lpsr_pkg.sv @@
package lpsr_pkg;

   localparam int POOL_SIZE = 16;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int LIFE_W    = 16;
   localparam logic [LIFE_W-1:0] STEP_RESET = 16'd256;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NOP    = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_RM_RD,
      S_RM_MV,
      S_RM_CLR,
      S_DEC_RD,
      S_DEC_WR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SW_MV,
      S_SW_CLR,
      S_DONE
   } ctl_state_type;

   typedef enum logic [0:0] {
      RA_IDX,
      RA_LAST
   } rd_addr_type;

   typedef enum logic [1:0] {
      WA_LIVE,
      WA_IDX,
      WA_LAST
   } wr_addr_type;

   typedef enum logic [1:0] {
      WD_LIFE,
      WD_RDATA,
      WD_DEC,
      WD_ZERO
   } wr_data_type;

   typedef struct packed {
      logic        accept;
      logic        rd_en;
      rd_addr_type rd_sel;
      logic        wr_en;
      wr_addr_type wa_sel;
      wr_data_type wd_sel;
      logic        live_inc;
      logic        live_dec;
      logic        idx_inc;
      logic        idx_clr;
      logic        exp_inc;
      logic        added_set;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic out_range;
      logic empty;
      logic idx_last;
      logic rd_zero;
   } dp_stat_type;

endpackage

@@ rtl/core/lpsr_ctrl.sv @@
module lpsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lpsr_pkg::dp_stat_type stat,
   output lpsr_pkg::dp_cmd_type  cmd
);
   import lpsr_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   act_type       act;

   assign act      = act_type'(req_action);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (act)
                  ACT_ADD:    state_in = stat.full ? S_DONE : S_ADD;
                  ACT_REMOVE: state_in = stat.out_range ? S_DONE : S_RM_RD;
                  ACT_TICK:   state_in = stat.empty ? S_DONE : S_DEC_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_ADD:      state_in = S_DONE;
         S_RM_RD:    state_in = S_RM_MV;
         S_RM_MV:    state_in = S_RM_CLR;
         S_RM_CLR:   state_in = S_DONE;
         S_DEC_RD:   state_in = S_DEC_WR;
         S_DEC_WR:   state_in = stat.idx_last ? S_SCAN_RD : S_DEC_RD;
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (stat.rd_zero)       state_in = S_SW_MV;
            else if (stat.idx_last) state_in = S_DONE;
            else                    state_in = S_SCAN_RD;
         end
         S_SW_MV:    state_in = S_SW_CLR;
         // slot idx gets rechecked unless it was the last live one
         S_SW_CLR:   state_in = stat.idx_last ? S_DONE : S_SCAN_RD;
         S_DONE:     state_in = out_free ? S_IDLE : S_DONE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RA_IDX;
      cmd.wa_sel = WA_IDX;
      cmd.wd_sel = WD_ZERO;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
         end
         S_ADD: begin
            cmd.wr_en     = 1'b1;
            cmd.wa_sel    = WA_LIVE;
            cmd.wd_sel    = WD_LIFE;
            cmd.live_inc  = 1'b1;
            cmd.added_set = 1'b1;
         end
         S_RM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_LAST;
         end
         S_RM_MV: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
         end
         S_RM_CLR: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_LAST;
            cmd.wd_sel   = WD_ZERO;
            cmd.live_dec = 1'b1;
         end
         S_DEC_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_IDX;
         end
         S_DEC_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_IDX;
            cmd.wd_sel  = WD_DEC;
            cmd.idx_clr = stat.idx_last;
            cmd.idx_inc = !stat.idx_last;
         end
         S_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_IDX;
         end
         S_SCAN_CHK: begin
            if (stat.rd_zero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_LAST;
            end else begin
               cmd.idx_inc = !stat.idx_last;
            end
         end
         S_SW_MV: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
         end
         S_SW_CLR: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_LAST;
            cmd.wd_sel   = WD_ZERO;
            cmd.live_dec = 1'b1;
            cmd.exp_inc  = 1'b1;
         end
         S_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd.accept = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)       rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/lpsr_dpath.sv @@
module lpsr_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  lpsr_pkg::dp_cmd_type  cmd,
   output lpsr_pkg::dp_stat_type stat,
   input  logic [1:0]            req_action,
   input  logic [15:0]           req_lifetime,
   input  logic [3:0]            req_slot_index,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_added_slot,
   output logic [4:0]            rsp_expired_count,
   output logic [4:0]            rsp_live_count
);
   import lpsr_pkg::*;

   logic [LIFE_W-1:0] mem [POOL_SIZE];

   logic [LIFE_W-1:0] step_ff;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  exp_ff, exp_in;
   logic [IDX_W-1:0]  added_ff, added_in;
   status_type        status_ff, status_in;
   logic [LIFE_W-1:0] life_ff;
   logic [LIFE_W-1:0] rdata_ff;

   logic [1:0]        out_status_ff;
   logic [IDX_W-1:0]  out_added_ff;
   logic [CNT_W-1:0]  out_exp_ff;
   logic [CNT_W-1:0]  out_live_ff;

   logic [IDX_W-1:0]  last;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [LIFE_W-1:0] wr_data;
   logic [LIFE_W-1:0] dec_val;
   act_type           act;

   assign act  = act_type'(req_action);
   assign last = IDX_W'(live_ff - CNT_W'(1));

   assign stat.full      = (live_ff == CNT_W'(POOL_SIZE));
   assign stat.out_range = (CNT_W'(req_slot_index) >= live_ff);
   assign stat.empty     = (live_ff == '0);
   assign stat.idx_last  = (idx_ff == last);
   assign stat.rd_zero   = (rdata_ff == '0);

   assign dec_val = (rdata_ff > step_ff) ? (rdata_ff - step_ff) : '0;

   always_comb begin
      case (cmd.rd_sel)
         RA_LAST: rd_addr = last;
         default: rd_addr = idx_ff;
      endcase
      case (cmd.wa_sel)
         WA_LIVE: wr_addr = IDX_W'(live_ff);
         WA_LAST: wr_addr = last;
         default: wr_addr = idx_ff;
      endcase
      case (cmd.wd_sel)
         WD_LIFE:  wr_data = life_ff;
         WD_RDATA: wr_data = rdata_ff;
         WD_DEC:   wr_data = dec_val;
         default:  wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      live_in   = live_ff;
      idx_in    = idx_ff;
      exp_in    = exp_ff;
      added_in  = added_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         idx_in    = (act == ACT_REMOVE) ? IDX_W'(req_slot_index) : '0;
         exp_in    = '0;
         added_in  = '0;
         status_in = ST_OK;
         if (act == ACT_ADD && stat.full)             status_in = ST_FULL;
         else if (act == ACT_REMOVE && stat.out_range) status_in = ST_RANGE;
      end else begin
         if (cmd.live_inc) live_in = live_ff + CNT_W'(1);
         if (cmd.live_dec) live_in = live_ff - CNT_W'(1);
         if (cmd.idx_inc)  idx_in  = idx_ff + IDX_W'(1);
         if (cmd.idx_clr)  idx_in  = '0;
         if (cmd.exp_inc)  exp_in  = exp_ff + CNT_W'(1);
         if (cmd.added_set) added_in = IDX_W'(live_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         live_ff <= '0;
      end else begin
         if (csr_write_enable) step_ff <= csr_write_data;
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      exp_ff    <= exp_in;
      added_ff  <= added_in;
      status_ff <= status_in;
      if (cmd.accept) life_ff <= req_lifetime;
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_added_ff  <= added_ff;
         out_exp_ff    <= exp_ff;
         out_live_ff   <= live_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_added_slot    = 4'(out_added_ff);
   assign rsp_expired_count = 5'(out_exp_ff);
   assign rsp_live_count    = 5'(out_live_ff);

endmodule

@@ rtl/core/lifetime_pool_swap_remove.sv @@
// Add runs S_ADD, remove S_RM_RD, S_RM_MV, S_RM_CLR; a refused or no-op word skips to
// S_DONE, which loads the result registers behind rsp_valid. Tick: an S_DEC_RD/S_DEC_WR
// pass over the N live entries, then an S_SCAN_RD/S_SCAN_CHK scan with S_SW_MV/S_SW_CLR
// per expired entry. One word in flight; the next word is taken in the cycle rsp_valid
// rises, later while an earlier result waits on rsp_stall. Single-port pool memory.
// Reset (synchronous, active high) empties the pool and sets tick_step to 1.0.
module lifetime_pool_swap_remove (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_lifetime,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_added_slot,
   output logic [4:0]  rsp_expired_count,
   output logic [4:0]  rsp_live_count,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import lpsr_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lpsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   lpsr_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_lifetime      (req_lifetime),
      .req_slot_index    (req_slot_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_status        (rsp_status),
      .rsp_added_slot    (rsp_added_slot),
      .rsp_expired_count (rsp_expired_count),
      .rsp_live_count    (rsp_live_count)
   );

endmodule
